/* hdl/lvs_pkg.sv */
// Shared types, constants and codes for the LFU victim-select engine.
package lvs_pkg;

	// Defaults for the top-level parameters
	localparam int SETS_DEF       = 64;
	localparam int WAYS_DEF       = 8;
	localparam int COUNT_BITS_DEF = 16;
	localparam int TIME_BITS_DEF  = 32;

	// Fixed port field widths
	localparam int CMD_W     = 2;
	localparam int SET_IDX_W = 6;
	localparam int WAY_IDX_W = 3;
	localparam int NOW_W     = 32;
	localparam int VICTIM_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_INVALIDATE = 2'd0,
		CMD_TOUCH      = 2'd1,
		CMD_FILL       = 2'd2,
		CMD_FIND       = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_SCAN,
		ST_SCAN_END,
		ST_RESULT
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic in_ready;
		logic capture;
		logic clr_en;
		logic upd_rd;
		logic upd_wr;
		logic scan_start;
		logic scan_rd;
		logic out_load;
	} ctrl_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic set_ok;
		logic way_ok;
		logic is_find;
		logic scan_last;
		logic out_free;
	} ctrl_sts_t;

endpackage

/* hdl/lvs_ctrl.sv */
// Controller state machine: clear pass, command dispatch, update and scan sequencing.
module lvs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  lvs_pkg::ctrl_sts_t sts,
	output lvs_pkg::ctrl_cmd_t cmd
);

	lvs_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lvs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lvs_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_nxt = lvs_pkg::ST_IDLE;
			end
			lvs_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = lvs_pkg::ST_DISPATCH;
			end
			lvs_pkg::ST_DISPATCH: begin
				priority if (!sts.set_ok) state_nxt = lvs_pkg::ST_IDLE;
				else if (sts.is_find) state_nxt = lvs_pkg::ST_SCAN;
				else if (!sts.way_ok) state_nxt = lvs_pkg::ST_IDLE;
				else state_nxt = lvs_pkg::ST_UPD_RD;
			end
			lvs_pkg::ST_UPD_RD:   state_nxt = lvs_pkg::ST_UPD_WR;
			lvs_pkg::ST_UPD_WR:   state_nxt = lvs_pkg::ST_IDLE;
			lvs_pkg::ST_SCAN: begin
				if (sts.scan_last) state_nxt = lvs_pkg::ST_SCAN_END;
			end
			lvs_pkg::ST_SCAN_END: state_nxt = lvs_pkg::ST_RESULT;
			lvs_pkg::ST_RESULT: begin
				if (sts.out_free) state_nxt = lvs_pkg::ST_IDLE;
			end
			default: state_nxt = lvs_pkg::ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			lvs_pkg::ST_CLEAR: cmd.clr_en = 1'b1;
			lvs_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.capture  = in_valid;
			end
			lvs_pkg::ST_DISPATCH: cmd.scan_start = sts.set_ok & sts.is_find;
			lvs_pkg::ST_UPD_RD:   cmd.upd_rd = 1'b1;
			lvs_pkg::ST_UPD_WR:   cmd.upd_wr = 1'b1;
			lvs_pkg::ST_SCAN:     cmd.scan_rd = 1'b1;
			lvs_pkg::ST_SCAN_END: cmd = '0;
			lvs_pkg::ST_RESULT:   cmd.out_load = sts.out_free;
			default:              cmd = '0;
		endcase
	end

endmodule

/* hdl/lvs_dp.sv */
// Datapath: command capture, replacement-state memory, way scan and result register.
module lvs_dp #(
	parameter int SETS       = lvs_pkg::SETS_DEF,
	parameter int WAYS       = lvs_pkg::WAYS_DEF,
	parameter int COUNT_BITS = lvs_pkg::COUNT_BITS_DEF,
	parameter int TIME_BITS  = lvs_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lvs_pkg::ctrl_cmd_t             cmd,
	output lvs_pkg::ctrl_sts_t             sts,
	input  logic [lvs_pkg::CMD_W-1:0]      command,
	input  logic [lvs_pkg::SET_IDX_W-1:0]  set_index,
	input  logic [lvs_pkg::WAY_IDX_W-1:0]  way,
	input  logic [lvs_pkg::NOW_W-1:0]      now,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lvs_pkg::VICTIM_W-1:0]   victim_way
);

	localparam int DEPTH  = SETS * WAYS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ENT_W  = COUNT_BITS + TIME_BITS;

	// captured command
	logic [lvs_pkg::CMD_W-1:0]     cmd_q;
	logic [lvs_pkg::SET_IDX_W-1:0] set_q;
	logic [lvs_pkg::WAY_IDX_W-1:0] way_q;
	logic [TIME_BITS-1:0]          now_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= command;
			set_q <= set_index;
			way_q <= way;
			now_q <= TIME_BITS'(now);
		end
	end

	// counters
	logic [ADDR_W-1:0] clr_addr_q;
	logic [WAY_W-1:0]  scan_w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			scan_w_q   <= '0;
		end else begin
			if (cmd.clr_en) clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (cmd.scan_start) scan_w_q <= '0;
			else if (cmd.scan_rd) scan_w_q <= scan_w_q + WAY_W'(1);
		end
	end

	// addressing
	logic [ADDR_W-1:0] base_addr, upd_addr, rd_addr, wr_addr;
	assign base_addr = ADDR_W'(ADDR_W'(set_q) * ADDR_W'(WAYS));
	assign upd_addr  = base_addr + ADDR_W'(way_q);
	assign rd_addr   = cmd.scan_rd ? (base_addr + ADDR_W'(scan_w_q)) : upd_addr;
	assign wr_addr   = cmd.clr_en ? clr_addr_q : upd_addr;

	// entry memory: {count, time}
	logic [ENT_W-1:0] mem [DEPTH];
	logic [ENT_W-1:0] rd_data_q;
	logic [ENT_W-1:0] wr_data;
	logic             mem_we, mem_re;

	assign mem_we = cmd.clr_en | cmd.upd_wr;
	assign mem_re = cmd.upd_rd | cmd.scan_rd;

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		if (mem_re) rd_data_q <= mem[rd_addr];
	end

	logic [COUNT_BITS-1:0] rd_cnt;
	logic [TIME_BITS-1:0]  rd_time;
	assign rd_cnt  = rd_data_q[ENT_W-1:TIME_BITS];
	assign rd_time = rd_data_q[TIME_BITS-1:0];

	// read-modify-write value
	logic [COUNT_BITS-1:0] new_cnt;
	logic [TIME_BITS-1:0]  new_time;

	always_comb begin
		new_cnt  = '0;
		new_time = '0;
		unique case (lvs_pkg::cmd_t'(cmd_q))
			lvs_pkg::CMD_INVALIDATE: begin
				new_cnt  = '0;
				new_time = '0;
			end
			lvs_pkg::CMD_TOUCH: begin
				new_cnt  = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
				new_time = now_q;
			end
			lvs_pkg::CMD_FILL: begin
				new_cnt  = COUNT_BITS'(1);
				new_time = now_q;
			end
			lvs_pkg::CMD_FIND: begin
				new_cnt  = rd_cnt;
				new_time = rd_time;
			end
			default: begin
				new_cnt  = rd_cnt;
				new_time = rd_time;
			end
		endcase
	end

	assign wr_data = cmd.clr_en ? '0 : {new_cnt, new_time};

	// scan compare stage
	logic                  scan_vld_s1, scan_first_s1;
	logic [WAY_W-1:0]      scan_w_s1;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [TIME_BITS-1:0]  best_time_q;
	logic [WAY_W-1:0]      best_way_q;
	logic                  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		scan_first_s1 <= (scan_w_q == '0);
		scan_w_s1     <= scan_w_q;
	end

	// lower count wins, then older time; equal keeps the lower way
	assign take = scan_first_s1 || (rd_cnt < best_cnt_q) ||
		((rd_cnt == best_cnt_q) && (rd_time < best_time_q));

	always_ff @(posedge clk) begin
		if (scan_vld_s1 && take) begin
			best_cnt_q  <= rd_cnt;
			best_time_q <= rd_time;
			best_way_q  <= scan_w_s1;
		end
	end

	// result register
	logic                        out_valid_q;
	logic [lvs_pkg::VICTIM_W-1:0] victim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) victim_q <= lvs_pkg::VICTIM_W'(best_way_q);
	end

	assign out_valid  = out_valid_q;
	assign victim_way = victim_q;

	// status
	assign sts.clr_last  = (clr_addr_q == ADDR_W'(DEPTH - 1));
	assign sts.set_ok    = (32'(set_q) < SETS);
	assign sts.way_ok    = (32'(way_q) < WAYS);
	assign sts.is_find   = (lvs_pkg::cmd_t'(cmd_q) == lvs_pkg::CMD_FIND);
	assign sts.scan_last = (scan_w_q == WAY_W'(WAYS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while pending");

	// clear pass and updates never share the write port
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_en && (cmd.upd_wr || cmd.scan_rd || cmd.capture)))
		else $error("memory write conflict during clear pass");

	// a loaded victim always names an existing way
	a_victim_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (32'(victim_q) < WAYS || WAYS > (1 << lvs_pkg::VICTIM_W)))
		else $error("victim way out of range");

	// compare stage only follows a scan read
	a_scan_follow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |=> scan_vld_s1)
		else $error("scan read not followed by compare");

endmodule

/* hdl/lfu_victim_select_lru_tiebreak.sv */
// Top level of the LFU replacement-state engine with LRU tie-break.
//
//  channel | signals                              | direction | transaction
//  --------+--------------------------------------+-----------+-------------------------------
//  in      | in_valid in_ready command set_index  | sink      | one command on a set/way
//          | way now                              |           |
//  out     | out_valid out_ready victim_way       | source    | one victim, find victim only
//
//  Update commands (invalidate, touch, fill) pass through accept, decode, memory read and
//  memory write. Find victim does one memory read per way through the single read port,
//  then a final compare and the result step.
//  After reset a clearing pass writes zero to all SETS * WAYS entries, one per cycle;
//  in_ready stays low until it is done.
//  A finished victim waits in the output register; the next transaction is accepted
//  meanwhile, and only a following find victim stalls in its result cycle on out_ready.
//  Commands with a set out of range, or updates with a way out of range, change nothing.
module lfu_victim_select_lru_tiebreak #(
	parameter int SETS       = lvs_pkg::SETS_DEF,
	parameter int WAYS       = lvs_pkg::WAYS_DEF,
	parameter int COUNT_BITS = lvs_pkg::COUNT_BITS_DEF,
	parameter int TIME_BITS  = lvs_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lvs_pkg::CMD_W-1:0]     command,
	input  logic [lvs_pkg::SET_IDX_W-1:0] set_index,
	input  logic [lvs_pkg::WAY_IDX_W-1:0] way,
	input  logic [lvs_pkg::NOW_W-1:0]     now,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lvs_pkg::VICTIM_W-1:0]  victim_way
);

	lvs_pkg::ctrl_cmd_t ctl_cmd;
	lvs_pkg::ctrl_sts_t ctl_sts;

	// sequencing: clear pass, dispatch, read-modify-write, scan
	lvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	// entry memory, scan compare and result register
	lvs_dp #(
		.SETS       (SETS),
		.WAYS       (WAYS),
		.COUNT_BITS (COUNT_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ctl_cmd),
		.sts        (ctl_sts),
		.command    (command),
		.set_index  (set_index),
		.way        (way),
		.now        (now),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.victim_way (victim_way)
	);

	assign in_ready = ctl_cmd.in_ready;

endmodule

/* verif/tb_lfu_victim_select_lru_tiebreak.sv */
// Self-checking testbench for the LFU victim-select engine with LRU tie-break.
`timescale 1ns / 1ps

module tb_lfu_victim_select_lru_tiebreak;

	// Sizes as the block is built here (defaults)
	localparam int NSETS     = lvs_pkg::SETS_DEF;
	localparam int NWAYS     = lvs_pkg::WAYS_DEF;
	localparam int IDX_W     = lvs_pkg::SET_IDX_W + lvs_pkg::WAY_IDX_W;
	localparam int RAND_CMDS = 700;
	// Settle time after the last victim
	localparam int TAIL_CYCLES = NWAYS + 12;

	// One command transaction plus the sender's pacing for it
	typedef struct {
		lvs_pkg::cmd_t                 cmd;
		logic [lvs_pkg::SET_IDX_W-1:0] set_idx;
		logic [lvs_pkg::WAY_IDX_W-1:0] way_sel;
		logic [lvs_pkg::NOW_W-1:0]     stamp;
		int unsigned                   gap;    // idle cycles before valid goes up
		bit                            drain;  // hold off until every victim is back
	} cmd_item_t;

	typedef struct {
		logic [lvs_pkg::SET_IDX_W-1:0] set_idx;
		logic [lvs_pkg::VICTIM_W-1:0]  victim;
	} victim_exp_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic [lvs_pkg::CMD_W-1:0]     command   = lvs_pkg::CMD_INVALIDATE;
	logic [lvs_pkg::SET_IDX_W-1:0] set_index = '0;
	logic [lvs_pkg::WAY_IDX_W-1:0] way       = '0;
	logic [lvs_pkg::NOW_W-1:0]     now       = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [lvs_pkg::VICTIM_W-1:0]  victim_way;

	lfu_victim_select_lru_tiebreak dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.set_index  (set_index),
		.way        (way),
		.now        (now),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.victim_way (victim_way)
	);

	always #5 clk = ~clk;

	// Shadow of the replacement state, indexed {set, way}
	logic [lvs_pkg::COUNT_BITS_DEF-1:0] use_cnt    [2**IDX_W];
	logic [lvs_pkg::TIME_BITS_DEF-1:0]  touch_time [2**IDX_W];

	cmd_item_t   pending_cmds[$];
	victim_exp_t victim_q[$];

	int unsigned total_cmds     = 0;
	int unsigned cmds_accepted  = 0;
	int unsigned victims_seen   = 0;
	int unsigned mismatches     = 0;
	int unsigned gap_cnt        = 0;
	int unsigned stall_cnt      = 0;
	int unsigned cmd_hist[4]    = '{default: 0};
	bit          calm_stretch   = 1'b0;

	// Copy of the transaction currently on the input port
	cmd_item_t pending_item_hold;

	// Lowest count wins; equal counts go to the older time, then the lower way
	function automatic logic [lvs_pkg::VICTIM_W-1:0] lfu_pick(
			input logic [lvs_pkg::SET_IDX_W-1:0] s);
		logic [lvs_pkg::WAY_IDX_W-1:0] best;
		logic [IDX_W-1:0]              ci;
		logic [IDX_W-1:0]              bi;
		best = '0;
		for (int w = 1; w < NWAYS; w++) begin
			ci = {s, lvs_pkg::WAY_IDX_W'(w)};
			bi = {s, best};
			if (use_cnt[ci] < use_cnt[bi])
				best = lvs_pkg::WAY_IDX_W'(w);
			else if (use_cnt[ci] == use_cnt[bi] && touch_time[ci] < touch_time[bi])
				best = lvs_pkg::WAY_IDX_W'(w);
		end
		return lvs_pkg::VICTIM_W'(best);
	endfunction

	// Update the shadow state for one accepted command; a find queues its victim
	task automatic track_command(input cmd_item_t it);
		logic [IDX_W-1:0] idx;
		idx = {it.set_idx, it.way_sel};
		cmd_hist[it.cmd]++;
		if (int'(it.set_idx) < NSETS) begin
			if (it.cmd == lvs_pkg::CMD_FIND) begin
				victim_q.push_back('{it.set_idx, lfu_pick(it.set_idx)});
			end else if (int'(it.way_sel) < NWAYS) begin
				case (it.cmd)
					lvs_pkg::CMD_INVALIDATE: begin
						use_cnt[idx]    = '0;
						touch_time[idx] = '0;
					end
					lvs_pkg::CMD_TOUCH: begin
						// saturating count, time is recorded regardless
						if (use_cnt[idx] != '1)
							use_cnt[idx] = use_cnt[idx] + lvs_pkg::COUNT_BITS_DEF'(1);
						touch_time[idx] = lvs_pkg::TIME_BITS_DEF'(it.stamp);
					end
					lvs_pkg::CMD_FILL: begin
						use_cnt[idx]    = lvs_pkg::COUNT_BITS_DEF'(1);
						touch_time[idx] = lvs_pkg::TIME_BITS_DEF'(it.stamp);
					end
					default: ;
				endcase
			end
		end
	endtask

	task automatic queue_cmd(input lvs_pkg::cmd_t c, input int s, input int w,
			input logic [lvs_pkg::NOW_W-1:0] t, input bit drain = 1'b0);
		cmd_item_t it;
		it.cmd     = c;
		it.set_idx = lvs_pkg::SET_IDX_W'(s);
		it.way_sel = lvs_pkg::WAY_IDX_W'(w);
		it.stamp   = t;
		it.gap     = calm_stretch ? 0 : $urandom_range(0, 6);
		it.drain   = drain;
		pending_cmds.push_back(it);
		total_cmds++;
	endtask

	// Driver: one transaction in flight; valid and payload hold until accepted.
	// in_valid gets exactly one nonblocking write per edge so a back-to-back
	// item keeps valid high without a low/high pair in the same step.
	always @(posedge clk or negedge arst_n) begin
		cmd_item_t it;
		logic      busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_cnt = 0;
		end else begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				track_command(pending_item_hold);
				cmds_accepted++;
				busy = 1'b0;
				gap_cnt = (pending_cmds.size() > 0) ? pending_cmds[0].gap : 0;
			end
			if (!busy) begin
				if (gap_cnt > 0) begin
					gap_cnt--;
				end else if (pending_cmds.size() > 0 &&
						!(pending_cmds[0].drain && victim_q.size() > 0)) begin
					it = pending_cmds.pop_front();
					pending_item_hold = it;
					command   <= it.cmd;
					set_index <= it.set_idx;
					way       <= it.way_sel;
					now       <= it.stamp;
					busy = 1'b1;
				end
			end
			in_valid <= busy;
		end
	end

	// Monitor: random back-pressure on the result channel, with calm runs of
	// 16 results out of every 64 where out_ready stays up.
	always @(posedge clk or negedge arst_n) begin
		victim_exp_t exp_v;
		logic        rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_cnt = 0;
		end else begin
			rdy = out_ready;
			if (out_valid && out_ready) begin
				if (victim_q.size() == 0) begin
					$display("%0t: unexpected victim transaction, expected none, actual %0d",
						$time, victim_way);
					mismatches++;
				end else begin
					exp_v = victim_q.pop_front();
					if (victim_way !== exp_v.victim) begin
						$display("%0t: victim_way mismatch in set %0d, expected %0d, actual %0d",
							$time, exp_v.set_idx, exp_v.victim, victim_way);
						mismatches++;
					end
				end
				victims_seen++;
				stall_cnt = (victims_seen % 64 < 16) ? 0 : $urandom_range(0, 6);
				rdy = 1'b0;
			end
			if (!rdy) begin
				if (stall_cnt > 0)
					stall_cnt--;
				else
					rdy = 1'b1;
			end
			out_ready <= rdy;
		end
	end

	// Stimulus and end of run
	initial begin
		logic [lvs_pkg::NOW_W-1:0] tnow;
		int                        r;
		int                        s;
		lvs_pkg::cmd_t             c;

		for (int i = 0; i < 2**IDX_W; i++) begin
			use_cnt[i]    = '0;
			touch_time[i] = '0;
		end

		// Directed: fresh state, field extremes, every command, time and way ties
		queue_cmd(lvs_pkg::CMD_FIND, 0, 0, '0);                   // all zero: lowest way
		queue_cmd(lvs_pkg::CMD_FILL, NSETS - 1, NWAYS - 1, '1);   // max set, way and time
		queue_cmd(lvs_pkg::CMD_FIND, NSETS - 1, NWAYS - 1, '0);
		for (int w = 0; w < NWAYS - 1; w++)                      // equal counts; w3, w5 oldest
			queue_cmd(lvs_pkg::CMD_FILL, NSETS - 1, w, (w == 3 || w == 5) ? '0 : '1);
		queue_cmd(lvs_pkg::CMD_FIND, NSETS - 1, 0, '1);           // time tie: lower way
		queue_cmd(lvs_pkg::CMD_TOUCH, NSETS - 1, 3, 32'd1);
		queue_cmd(lvs_pkg::CMD_FIND, NSETS - 1, 3, '0);
		queue_cmd(lvs_pkg::CMD_INVALIDATE, NSETS - 1, 6, '1);
		queue_cmd(lvs_pkg::CMD_FIND, NSETS - 1, 2, '0);
		queue_cmd(lvs_pkg::CMD_TOUCH, NSETS - 1, 6, 32'h8000_0000); // touch from zero count
		queue_cmd(lvs_pkg::CMD_FIND, NSETS - 1, 5, '1);
		queue_cmd(lvs_pkg::CMD_INVALIDATE, 0, 0, '0);
		queue_cmd(lvs_pkg::CMD_TOUCH, 0, 0, '0);
		queue_cmd(lvs_pkg::CMD_FIND, 0, 7, '0);

		// Random: hot sets for dense count/time ties, mostly rising time with
		// repeats and occasional wild stamps
		tnow = $urandom_range(0, 1000);
		for (int i = 0; i < RAND_CMDS; i++) begin
			calm_stretch = (i % 200) >= 150;
			r = $urandom_range(0, 99);
			c = (r < 10) ? lvs_pkg::CMD_INVALIDATE : (r < 45) ? lvs_pkg::CMD_TOUCH :
				(r < 70) ? lvs_pkg::CMD_FILL : lvs_pkg::CMD_FIND;
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 3))
					0: s = 0;
					1: s = NSETS - 1;
					2: s = 21;
					default: s = 42;
				endcase
			end else begin
				s = $urandom_range(0, NSETS - 1);
			end
			case ($urandom_range(0, 9))
				0: tnow = $urandom;
				1: ;                                   // repeat stamp for a time tie
				default: tnow = tnow + $urandom_range(1, 1000);
			endcase
			queue_cmd(c, s, $urandom_range(0, NWAYS - 1), tnow, i == 0 || i == 350);
		end

		while (cmds_accepted != total_cmds)
			@(posedge clk);
		while (victim_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d command transactions: %0d invalidate, %0d touch, %0d fill, %0d find.",
			cmds_accepted, cmd_hist[lvs_pkg::CMD_INVALIDATE], cmd_hist[lvs_pkg::CMD_TOUCH],
			cmd_hist[lvs_pkg::CMD_FILL], cmd_hist[lvs_pkg::CMD_FIND]);
		$display("Checked %0d victim transactions over tie, extreme and stall cases; %0d mismatches.",
			victims_seen, mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Reset once, released at a rising clock edge
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog: well beyond the slowest legal run (clearing pass, stalls, random part)
	initial begin
		#2_000_000;
		$display("%0t: timeout with %0d of %0d commands accepted, %0d victims outstanding",
			$time, cmds_accepted, total_cmds, victim_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
